FILE: src/obb_pkg.sv
// Package for the oriented box overlap test: widths, latency and sine coefficients.
// Used by obb_overlap_test_unit; depends on nothing else.
`default_nettype none
package obb_pkg;

    localparam int COORD_BITS = 24;
    localparam int ANGLE_BITS = 16;

    localparam int SIZE_BITS  = COORD_BITS - 1;
    localparam int CTR_BITS   = COORD_BITS + 2;
    localparam int QUAD_LSB   = ANGLE_BITS - 2;
    localparam int Z_BITS     = 31;
    localparam int ZPROD_BITS = 2 * Z_BITS;
    localparam int Z_SHIFT    = 32 - ANGLE_BITS;
    localparam int Q_BITS     = 17;
    localparam int TRIG_BITS  = 16;
    localparam int PROD_BITS  = 2 * TRIG_BITS;
    localparam int DOT_BITS   = PROD_BITS + 1;
    localparam int DQ_BITS    = DOT_BITS - 15;
    localparam int D_BITS     = DQ_BITS - 1;
    localparam int CPROD_BITS = CTR_BITS + TRIG_BITS;
    localparam int CSUM_BITS  = CPROD_BITS + 1;
    localparam int EPROD_BITS = SIZE_BITS + D_BITS;
    localparam int ESUM_BITS  = EPROD_BITS + 1;
    localparam int PROJ_BITS  = CSUM_BITS + 1;

    localparam int LATENCY    = 13;
    localparam int ROUND_HALF = 16384;
    localparam int Q_MAX      = 32767;

    localparam logic [Z_BITS-1:0] POLY_A9 = Z_BITS'(172272);
    localparam logic [Z_BITS-1:0] POLY_A7 = Z_BITS'(5026994);
    localparam logic [Z_BITS-1:0] POLY_A5 = Z_BITS'(85569307);
    localparam logic [Z_BITS-1:0] POLY_A3 = Z_BITS'(693598670);
    localparam logic [Z_BITS-1:0] POLY_A1 = Z_BITS'(1686629713);

    typedef struct packed {
        logic signed [CTR_BITS-1:0] cx2;
        logic signed [CTR_BITS-1:0] cy2;
        logic [SIZE_BITS-1:0]       w;
        logic [SIZE_BITS-1:0]       h;
    } geo_t;

endpackage
`default_nettype wire

FILE: src/obb_overlap_test_unit.sv
// Overlap test of two rotated rectangles by separating axes, fully pipelined.
// Depends on obb_pkg for widths, coefficients and the box geometry type.
//
// Usage:
//   The input channel (in_valid, in_stall) carries one word per box pair:
//   corner, size and binary rotation angle of each box. The output channel
//   (out_valid, out_stall) returns one word per pair: overlap is 1 unless one
//   of the edge normals of either box shows a strict gap between the projections.
//   Throughput is one pair per cycle while not frozen; the 13 stages are set by
//   the sine polynomial (one multiply per stage in Horner form) followed by
//   projection and compare. All stages advance together. When out_stall holds
//   a valid result, the whole pipeline freezes and in_stall goes high in the
//   same cycle, so nothing is lost or repeated. Bubbles are not squeezed out
//   while frozen. Reset clears all valid bits; data registers are not reset.
`default_nettype none
module obb_overlap_test_unit (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    in_valid,
    output logic                                    in_stall,
    input  logic signed [obb_pkg::COORD_BITS-1:0]   first_left,
    input  logic signed [obb_pkg::COORD_BITS-1:0]   first_top,
    input  logic        [obb_pkg::SIZE_BITS-1:0]    first_width,
    input  logic        [obb_pkg::SIZE_BITS-1:0]    first_height,
    input  logic        [obb_pkg::ANGLE_BITS-1:0]   first_turn,
    input  logic signed [obb_pkg::COORD_BITS-1:0]   second_left,
    input  logic signed [obb_pkg::COORD_BITS-1:0]   second_top,
    input  logic        [obb_pkg::SIZE_BITS-1:0]    second_width,
    input  logic        [obb_pkg::SIZE_BITS-1:0]    second_height,
    input  logic        [obb_pkg::ANGLE_BITS-1:0]   second_turn,
    output logic                                    out_valid,
    input  logic                                    out_stall,
    output logic                                    overlap
);

    localparam int LAT = obb_pkg::LATENCY;
    localparam logic [obb_pkg::ANGLE_BITS-1:0] QUARTER =
        obb_pkg::ANGLE_BITS'(1) << obb_pkg::QUAD_LSB;
    localparam logic [obb_pkg::ANGLE_BITS-2:0] QUARTER_R =
        (obb_pkg::ANGLE_BITS-1)'(1) << obb_pkg::QUAD_LSB;

    logic [LAT:1] valid_reg;
    logic         advance;

    assign advance   = !(valid_reg[LAT] && out_stall);
    assign in_stall  = !advance;
    assign out_valid = valid_reg[LAT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (advance)
        begin
            valid_reg <= {valid_reg[LAT-1:1], in_valid};
        end
    end

    // Angle index k: 0 first sine, 1 first cosine, 2 second sine, 3 second cosine.
    logic [obb_pkg::ANGLE_BITS-1:0] ang   [0:3];
    logic [obb_pkg::ANGLE_BITS-2:0] rr    [0:3];
    logic [obb_pkg::Z_BITS-1:0]     z_next[0:3];
    logic                           neg_next[0:3];
    obb_pkg::geo_t                  geo_next[0:1];

    logic [obb_pkg::Z_BITS-1:0]     z_reg  [1:6][0:3];
    logic                           neg_reg[1:7][0:3];
    logic [obb_pkg::Z_BITS-1:0]     z2_reg [2:5][0:3];
    logic [obb_pkg::Z_BITS-1:0]     p_reg  [3:6][0:3];
    logic [obb_pkg::Z_BITS-1:0]     s_reg  [0:3];
    logic signed [obb_pkg::TRIG_BITS-1:0] trig_reg[0:3];
    obb_pkg::geo_t                  geo_reg[1:10][0:1];

    logic [obb_pkg::Z_BITS-1:0]     z2_next[0:3];
    logic [obb_pkg::Z_BITS-1:0]     p_next [3:6][0:3];
    logic [obb_pkg::Z_BITS-1:0]     s_next [0:3];
    logic signed [obb_pkg::TRIG_BITS-1:0] trig_next[0:3];
    logic [obb_pkg::ZPROD_BITS-1:0] zz_prod[0:3];
    logic [obb_pkg::ZPROD_BITS-1:0] hp_prod[3:6][0:3];
    logic [obb_pkg::ZPROD_BITS-1:0] zs_prod[0:3];
    logic [obb_pkg::Z_BITS:0]       q_sum  [0:3];
    logic [obb_pkg::Q_BITS-1:0]     q_val  [0:3];
    logic [obb_pkg::TRIG_BITS-1:0]  q_sat  [0:3];
    logic [obb_pkg::Z_BITS-1:0]     coef   [3:6];
    logic [obb_pkg::Z_BITS-1:0]     p_prev [3:6][0:3];

    assign coef[3] = obb_pkg::POLY_A7;
    assign coef[4] = obb_pkg::POLY_A5;
    assign coef[5] = obb_pkg::POLY_A3;
    assign coef[6] = obb_pkg::POLY_A1;

    assign ang[0] = first_turn;
    assign ang[1] = first_turn + QUARTER;
    assign ang[2] = second_turn;
    assign ang[3] = second_turn + QUARTER;

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            // Second and fourth quadrants mirror the offset; the lower half is negated.
            rr[k] = ang[k][obb_pkg::QUAD_LSB]
                  ? QUARTER_R - (obb_pkg::ANGLE_BITS-1)'(ang[k][obb_pkg::QUAD_LSB-1:0])
                  : (obb_pkg::ANGLE_BITS-1)'(ang[k][obb_pkg::QUAD_LSB-1:0]);
            z_next[k]   = obb_pkg::Z_BITS'(rr[k]) << obb_pkg::Z_SHIFT;
            neg_next[k] = ang[k][obb_pkg::ANGLE_BITS-1];
        end
        geo_next[0].w   = first_width;
        geo_next[0].h   = first_height;
        geo_next[0].cx2 = (obb_pkg::CTR_BITS'(first_left) <<< 1)
                        + $signed(obb_pkg::CTR_BITS'(first_width));
        geo_next[0].cy2 = (obb_pkg::CTR_BITS'(first_top) <<< 1)
                        + $signed(obb_pkg::CTR_BITS'(first_height));
        geo_next[1].w   = second_width;
        geo_next[1].h   = second_height;
        geo_next[1].cx2 = (obb_pkg::CTR_BITS'(second_left) <<< 1)
                        + $signed(obb_pkg::CTR_BITS'(second_width));
        geo_next[1].cy2 = (obb_pkg::CTR_BITS'(second_top) <<< 1)
                        + $signed(obb_pkg::CTR_BITS'(second_height));
    end

    // Sine polynomial in Horner form, one product per stage.
    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            zz_prod[k] = obb_pkg::ZPROD_BITS'(z_reg[1][k]) * obb_pkg::ZPROD_BITS'(z_reg[1][k]);
            z2_next[k] = zz_prod[k][60:30];
            for (int n = 3; n <= 6; n++)
            begin
                p_prev[n][k]  = (n == 3) ? obb_pkg::POLY_A9 : p_reg[(n == 3) ? 3 : n-1][k];
                hp_prod[n][k] = obb_pkg::ZPROD_BITS'(z2_reg[n-1][k])
                              * obb_pkg::ZPROD_BITS'(p_prev[n][k]);
                p_next[n][k]  = coef[n] - hp_prod[n][k][60:30];
            end
            zs_prod[k] = obb_pkg::ZPROD_BITS'(z_reg[6][k]) * obb_pkg::ZPROD_BITS'(p_reg[6][k]);
            s_next[k]  = zs_prod[k][60:30];
            q_sum[k]   = (obb_pkg::Z_BITS+1)'(s_reg[k]) + (obb_pkg::Z_BITS+1)'(obb_pkg::ROUND_HALF);
            q_val[k]   = q_sum[k][obb_pkg::Z_BITS:15];
            q_sat[k]   = (q_val[k] > obb_pkg::Q_BITS'(obb_pkg::Q_MAX))
                       ? obb_pkg::TRIG_BITS'(obb_pkg::Q_MAX)
                       : q_val[k][obb_pkg::TRIG_BITS-1:0];
            trig_next[k] = neg_reg[7][k] ? -$signed(q_sat[k]) : $signed(q_sat[k]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int k = 0; k < 4; k++)
            begin
                z_reg[1][k]   <= z_next[k];
                neg_reg[1][k] <= neg_next[k];
                for (int n = 2; n <= 6; n++)
                begin
                    z_reg[n][k] <= z_reg[n-1][k];
                end
                for (int n = 2; n <= 7; n++)
                begin
                    neg_reg[n][k] <= neg_reg[n-1][k];
                end
                z2_reg[2][k] <= z2_next[k];
                for (int n = 3; n <= 5; n++)
                begin
                    z2_reg[n][k] <= z2_reg[n-1][k];
                end
                for (int n = 3; n <= 6; n++)
                begin
                    p_reg[n][k] <= p_next[n][k];
                end
                s_reg[k]    <= s_next[k];
                trig_reg[k] <= trig_next[k];
            end
            for (int j = 0; j < 2; j++)
            begin
                geo_reg[1][j] <= geo_next[j];
                for (int n = 2; n <= 10; n++)
                begin
                    geo_reg[n][j] <= geo_reg[n-1][j];
                end
            end
        end
    end

    // Projection stages. Axis i: 0,1 normals of the first box, 2,3 of the second.
    logic signed [obb_pkg::TRIG_BITS-1:0]  ux[0:3];
    logic signed [obb_pkg::TRIG_BITS-1:0]  uy[0:3];
    logic signed [obb_pkg::TRIG_BITS-1:0]  bc[0:1];
    logic signed [obb_pkg::TRIG_BITS-1:0]  bs[0:1];

    logic signed [obb_pkg::PROD_BITS-1:0]  pcx_reg[0:3][0:1];
    logic signed [obb_pkg::PROD_BITS-1:0]  psy_reg[0:3][0:1];
    logic signed [obb_pkg::PROD_BITS-1:0]  psx_reg[0:3][0:1];
    logic signed [obb_pkg::PROD_BITS-1:0]  pcy_reg[0:3][0:1];
    logic signed [obb_pkg::CPROD_BITS-1:0] ctx_reg[0:3][0:1];
    logic signed [obb_pkg::CPROD_BITS-1:0] cty_reg[0:3][0:1];

    logic signed [obb_pkg::DOT_BITS-1:0]   dot1[0:3][0:1];
    logic signed [obb_pkg::DOT_BITS-1:0]   dot2[0:3][0:1];
    logic signed [obb_pkg::DQ_BITS-1:0]    dq1 [0:3][0:1];
    logic signed [obb_pkg::DQ_BITS-1:0]    dq2 [0:3][0:1];
    logic signed [obb_pkg::DQ_BITS-1:0]    da1 [0:3][0:1];
    logic signed [obb_pkg::DQ_BITS-1:0]    da2 [0:3][0:1];
    logic [obb_pkg::D_BITS-1:0]            dabs1_next[0:3][0:1];
    logic [obb_pkg::D_BITS-1:0]            dabs2_next[0:3][0:1];
    logic signed [obb_pkg::CSUM_BITS-1:0]  ctr_next  [0:3][0:1];

    logic [obb_pkg::D_BITS-1:0]            dabs1_reg[0:3][0:1];
    logic [obb_pkg::D_BITS-1:0]            dabs2_reg[0:3][0:1];
    logic signed [obb_pkg::CSUM_BITS-1:0]  ctr10_reg[0:3][0:1];
    logic [obb_pkg::EPROD_BITS-1:0]        e1_reg   [0:3][0:1];
    logic [obb_pkg::EPROD_BITS-1:0]        e2_reg   [0:3][0:1];
    logic signed [obb_pkg::CSUM_BITS-1:0]  ctr11_reg[0:3][0:1];

    logic [obb_pkg::ESUM_BITS-1:0]         ext      [0:3][0:1];
    logic signed [obb_pkg::PROJ_BITS-1:0]  lo_next  [0:3][0:1];
    logic signed [obb_pkg::PROJ_BITS-1:0]  hi_next  [0:3][0:1];
    logic signed [obb_pkg::PROJ_BITS-1:0]  lo_reg   [0:3][0:1];
    logic signed [obb_pkg::PROJ_BITS-1:0]  hi_reg   [0:3][0:1];
    logic [3:0]                            gap;
    logic                                  overlap_reg;

    always_comb
    begin
        bs[0] = trig_reg[0];
        bc[0] = trig_reg[1];
        bs[1] = trig_reg[2];
        bc[1] = trig_reg[3];
        ux[0] = bc[0];
        uy[0] = bs[0];
        ux[1] = -bs[0];
        uy[1] = bc[0];
        ux[2] = bc[1];
        uy[2] = bs[1];
        ux[3] = -bs[1];
        uy[3] = bc[1];
    end

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            for (int j = 0; j < 2; j++)
            begin
                dot1[i][j] = obb_pkg::DOT_BITS'(pcx_reg[i][j]) + obb_pkg::DOT_BITS'(psy_reg[i][j])
                           + obb_pkg::DOT_BITS'(obb_pkg::ROUND_HALF);
                dot2[i][j] = obb_pkg::DOT_BITS'(pcy_reg[i][j]) - obb_pkg::DOT_BITS'(psx_reg[i][j])
                           + obb_pkg::DOT_BITS'(obb_pkg::ROUND_HALF);
                dq1[i][j]  = $signed(dot1[i][j][obb_pkg::DOT_BITS-1:15]);
                dq2[i][j]  = $signed(dot2[i][j][obb_pkg::DOT_BITS-1:15]);
                da1[i][j]  = dq1[i][j][obb_pkg::DQ_BITS-1] ? -dq1[i][j] : dq1[i][j];
                da2[i][j]  = dq2[i][j][obb_pkg::DQ_BITS-1] ? -dq2[i][j] : dq2[i][j];
                dabs1_next[i][j] = da1[i][j][obb_pkg::D_BITS-1:0];
                dabs2_next[i][j] = da2[i][j][obb_pkg::D_BITS-1:0];
                ctr_next[i][j]   = obb_pkg::CSUM_BITS'(ctx_reg[i][j])
                                 + obb_pkg::CSUM_BITS'(cty_reg[i][j]);

                ext[i][j] = obb_pkg::ESUM_BITS'(e1_reg[i][j]) + obb_pkg::ESUM_BITS'(e2_reg[i][j]);
                lo_next[i][j] = obb_pkg::PROJ_BITS'(ctr11_reg[i][j])
                              - $signed(obb_pkg::PROJ_BITS'(ext[i][j]));
                hi_next[i][j] = obb_pkg::PROJ_BITS'(ctr11_reg[i][j])
                              + $signed(obb_pkg::PROJ_BITS'(ext[i][j]));
            end
            // A strict gap on any axis separates the boxes; touching is overlap.
            gap[i] = (hi_reg[i][0] < lo_reg[i][1]) || (hi_reg[i][1] < lo_reg[i][0]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int i = 0; i < 4; i++)
            begin
                for (int j = 0; j < 2; j++)
                begin
                    pcx_reg[i][j] <= obb_pkg::PROD_BITS'(bc[j]) * obb_pkg::PROD_BITS'(ux[i]);
                    psy_reg[i][j] <= obb_pkg::PROD_BITS'(bs[j]) * obb_pkg::PROD_BITS'(uy[i]);
                    psx_reg[i][j] <= obb_pkg::PROD_BITS'(bs[j]) * obb_pkg::PROD_BITS'(ux[i]);
                    pcy_reg[i][j] <= obb_pkg::PROD_BITS'(bc[j]) * obb_pkg::PROD_BITS'(uy[i]);
                    ctx_reg[i][j] <= obb_pkg::CPROD_BITS'(geo_reg[8][j].cx2)
                                   * obb_pkg::CPROD_BITS'(ux[i]);
                    cty_reg[i][j] <= obb_pkg::CPROD_BITS'(geo_reg[8][j].cy2)
                                   * obb_pkg::CPROD_BITS'(uy[i]);
                    dabs1_reg[i][j] <= dabs1_next[i][j];
                    dabs2_reg[i][j] <= dabs2_next[i][j];
                    ctr10_reg[i][j] <= ctr_next[i][j];
                    e1_reg[i][j]    <= obb_pkg::EPROD_BITS'(geo_reg[10][j].w)
                                     * obb_pkg::EPROD_BITS'(dabs1_reg[i][j]);
                    e2_reg[i][j]    <= obb_pkg::EPROD_BITS'(geo_reg[10][j].h)
                                     * obb_pkg::EPROD_BITS'(dabs2_reg[i][j]);
                    ctr11_reg[i][j] <= ctr10_reg[i][j];
                    lo_reg[i][j]    <= lo_next[i][j];
                    hi_reg[i][j]    <= hi_next[i][j];
                end
            end
            overlap_reg <= !(|gap);
        end
    end

    assign overlap = overlap_reg;

endmodule
`default_nettype wire

FILE: src/obb_checker.sv
// Port-level checks for obb_overlap_test_unit, attached by bind.
// Depends on obb_overlap_test_unit's port names.
`default_nettype none
module obb_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_stall,
    input logic out_valid,
    input logic out_stall,
    input logic overlap
);

    // A held result keeps its word until it is taken.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result word dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(overlap))
        else $error("result word changed while stalled");

    // The input side is held back only by a blocked result.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without a blocked result");

    a_stall_pass: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |-> in_stall)
        else $error("input word taken while the pipeline is frozen");

endmodule

bind obb_overlap_test_unit obb_checker u_obb_checker (.*);
`default_nettype wire
